FILE: sv/epdu_pkg.sv
package epdu_pkg;

	localparam int POOL_DEPTH_DEF   = 16;
	localparam int NUM_CLUSTERS_DEF = 32;
	localparam int NODE_BITS_DEF    = 8;

	localparam int COST_W = 31;
	localparam int GEN_W  = 24;

	localparam logic [2:0] OP_LOAD     = 3'd0;
	localparam logic [2:0] OP_UPDATE   = 3'd1;
	localparam logic [2:0] OP_FARTHEST = 3'd2;
	localparam logic [2:0] OP_BEST     = 3'd3;
	localparam logic [2:0] OP_CLEAR    = 3'd4;

	localparam logic [1:0] KIND_STATUS  = 2'd0;
	localparam logic [1:0] KIND_ELEMENT = 2'd1;
	localparam logic [1:0] KIND_NONE    = 2'd2;

	localparam logic REG_ELITE_SIZE   = 1'b0;
	localparam logic REG_MIN_DISTANCE = 1'b1;

	localparam logic [4:0] ELITE_SIZE_RST   = 5'd10;
	localparam logic [5:0] MIN_DISTANCE_RST = 6'd3;
	localparam logic [GEN_W-1:0] GEN_RST    = 24'd1;
	localparam logic signed [31:0] NO_COST  = -32'sd1;

	typedef struct packed {
		logic [2:0]        opcode;
		logic [4:0]        element_index;
		logic [7:0]        element_value;
		logic [COST_W-1:0] cost;
		logic [GEN_W-1:0]  generation;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        result_kind;
		logic              accepted;
		logic signed [31:0] best_cost;
		logic [GEN_W-1:0]  best_generation;
		logic [4:0]        pool_count;
		logic [4:0]        out_index;
		logic [7:0]        out_value;
		logic signed [31:0] chosen_cost;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} ord_ctrl_t;

endpackage

FILE: sv/epdu_ram.sv
module epdu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: sv/epdu_order.sv
module epdu_order #(
	parameter int POOL_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  epdu_pkg::ord_ctrl_t               ctrl,
	input  logic [$clog2(POOL_DEPTH+1)-1:0]   pos,
	input  logic [$clog2(POOL_DEPTH+1)-1:0]   sel,
	input  logic [epdu_pkg::COST_W-1:0]       cin,
	output logic [$clog2(POOL_DEPTH+1)-1:0]   ord_rd,
	output logic [epdu_pkg::COST_W-1:0]       cost_rd
);
	import epdu_pkg::*;

	localparam int ENTRIES = POOL_DEPTH + 1;
	localparam int SB      = $clog2(ENTRIES);

	logic [SB-1:0]     ord_q  [ENTRIES];
	logic [COST_W-1:0] cost_q [ENTRIES];

	assign ord_rd  = ord_q[sel];
	assign cost_rd = cost_q[sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < ENTRIES; j++) begin
				ord_q[j] <= SB'(j);
			end
		end else begin
			for (int j = 0; j < ENTRIES; j++) begin
				if (ctrl.ins) begin
					if (j == int'(pos)) begin
						ord_q[j] <= ord_rd;
					end else if (j > int'(pos) && j <= int'(sel)) begin
						ord_q[j] <= ord_q[(j == 0) ? 0 : j - 1];
					end
				end else if (ctrl.rem) begin
					if (j == ENTRIES - 1) begin
						ord_q[j] <= ord_rd;
					end else if (j >= int'(sel)) begin
						ord_q[j] <= ord_q[j + 1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < ENTRIES; j++) begin
			if (ctrl.ins) begin
				if (j == int'(pos)) begin
					cost_q[j] <= cin;
				end else if (j > int'(pos) && j <= int'(sel)) begin
					cost_q[j] <= cost_q[(j == 0) ? 0 : j - 1];
				end
			end else if (ctrl.rem) begin
				if (j == ENTRIES - 1) begin
					cost_q[j] <= cost_rd;
				end else if (j >= int'(sel)) begin
					cost_q[j] <= cost_q[j + 1];
				end
			end
		end
	end
endmodule

FILE: sv/elite_pool_diversity_update.sv
// Channel  Dir  Signals                      Transfer when
// cmd      in   cmd_valid cmd_ready cmd      cmd_valid & cmd_ready
// rsp      out  rsp_valid rsp_ready rsp      rsp_valid & rsp_ready
// cfg      in   cfg_we cfg_index cfg_data    cfg_we
//
// One op at a time; cmd_ready is high only while the sequencer is idle.
// Load stays in the idle state. A Hamming pass compares one member with the candidate.
// Update: a cost search over the worse members, a pass per member, a copy of the
// candidate into the pool, one eviction per excess member and the best and status steps.
// Farthest query: a pass per member; the solution is then output one element at a time.
// Reset empties the pool at once; no clearing pass. rsp stalls hold the sequencer.
module elite_pool_diversity_update #(
	parameter int POOL_DEPTH   = epdu_pkg::POOL_DEPTH_DEF,
	parameter int NUM_CLUSTERS = epdu_pkg::NUM_CLUSTERS_DEF,
	parameter int NODE_BITS    = epdu_pkg::NODE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  epdu_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output epdu_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [5:0]     cfg_data
);
	import epdu_pkg::*;

	localparam int SB   = $clog2(POOL_DEPTH + 1);
	localparam int CNTB = $clog2(POOL_DEPTH + 2);
	localparam int CB   = $clog2(NUM_CLUSTERS);
	localparam int IB   = $clog2(NUM_CLUSTERS + 1);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_FIND   = 4'd1;
	localparam logic [3:0] ST_HAM    = 4'd2;
	localparam logic [3:0] ST_COPY   = 4'd3;
	localparam logic [3:0] ST_EVICT  = 4'd4;
	localparam logic [3:0] ST_BEST   = 4'd5;
	localparam logic [3:0] ST_STATUS = 4'd6;
	localparam logic [3:0] ST_NOSOL  = 4'd7;
	localparam logic [3:0] ST_ESET   = 4'd8;
	localparam logic [3:0] ST_ERD    = 4'd9;
	localparam logic [3:0] ST_ELD    = 4'd10;

	localparam logic [1:0] M_CHK   = 2'd0;
	localparam logic [1:0] M_PRUNE = 2'd1;
	localparam logic [1:0] M_FAR   = 2'd2;

	logic [3:0]        state_q;
	logic [1:0]        mode_q;
	logic [4:0]        es_q;
	logic [5:0]        md_q;
	logic [CNTB-1:0]   cnt_q, ptr_q, p_q, chosen_q;
	logic [IB-1:0]     i_q, dist_q, bestd_q;
	logic              found_q, acc_q, wasbest_q;
	logic [COST_W-1:0] cost_q, best_q, ccost_q;
	logic [GEN_W-1:0]  gen_q, bgen_q;
	logic [SB-1:0]     slot_q;
	logic              rdv_s1;
	logic [CB-1:0]     wcl_s1;
	logic              ovalid_q;
	rsp_t              out_q;

	logic [CNTB-1:0]   lim;
	logic [SB-1:0]     sel;
	logic [SB-1:0]     ord_rd;
	logic [COST_W-1:0] cost_rd;
	ord_ctrl_t         octl;
	logic [NODE_BITS-1:0] elem_rd, cand_rd;
	logic [SB+CB-1:0]  elem_raddr;
	logic              elem_we, cand_we;
	logic              mis;
	logic [IB-1:0]     dist_fin;
	logic              ham_end, lt, far_new, out_free, cmd_xfer, osend;
	logic signed [31:0] best_out;

	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_xfer  = cmd_valid && cmd_ready;
	assign rsp_valid = ovalid_q;
	assign rsp       = out_q;
	assign out_free  = !ovalid_q || rsp_ready;
	assign osend     = out_free
		&& (state_q == ST_STATUS || state_q == ST_NOSOL || state_q == ST_ELD);

	assign mis      = rdv_s1 && (elem_rd != cand_rd);
	assign dist_fin = dist_q + IB'(mis);
	assign ham_end  = (state_q == ST_HAM) && (i_q == IB'(NUM_CLUSTERS));
	assign lt       = 32'(dist_fin) < 32'(md_q);
	assign far_new  = dist_fin > bestd_q;
	assign best_out = (cnt_q == '0) ? NO_COST : 32'(best_q);

	always_comb begin
		if (es_q == '0) begin
			lim = CNTB'(1);
		end else if (32'(es_q) > POOL_DEPTH) begin
			lim = CNTB'(POOL_DEPTH);
		end else begin
			lim = CNTB'(es_q);
		end
	end

	always_comb begin
		unique case (state_q)
			ST_COPY:  sel = cnt_q[SB-1:0];
			ST_EVICT: sel = '0;
			ST_BEST:  sel = SB'(cnt_q - CNTB'(1));
			ST_ESET:  sel = chosen_q[SB-1:0];
			default:  sel = ptr_q[SB-1:0];
		endcase
	end

	always_comb begin
		octl.ins = (state_q == ST_COPY) && (i_q == IB'(NUM_CLUSTERS));
		octl.rem = (ham_end && mode_q == M_PRUNE && lt)
			|| (state_q == ST_EVICT && cnt_q > lim);
	end

	always_comb begin
		if (state_q == ST_HAM) begin
			elem_raddr = {ord_rd, i_q[CB-1:0]};
		end else begin
			elem_raddr = {slot_q, i_q[CB-1:0]};
		end
	end

	assign elem_we = rdv_s1 && (state_q == ST_COPY);
	assign cand_we = cmd_xfer && (cmd.opcode == OP_LOAD)
		&& (32'(cmd.element_index) < NUM_CLUSTERS);

	epdu_order #(.POOL_DEPTH(POOL_DEPTH)) u_order (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (octl),
		.pos     (p_q[SB-1:0]),
		.sel     (sel),
		.cin     (cost_q),
		.ord_rd  (ord_rd),
		.cost_rd (cost_rd)
	);

	epdu_ram #(.WIDTH(NODE_BITS), .DEPTH(2 ** (SB + CB))) u_elem (
		.clk   (clk),
		.we    (elem_we),
		.waddr ({ord_rd, wcl_s1}),
		.wdata (cand_rd),
		.raddr (elem_raddr),
		.rdata (elem_rd)
	);

	epdu_ram #(.WIDTH(NODE_BITS), .DEPTH(2 ** CB)) u_cand (
		.clk   (clk),
		.we    (cand_we),
		.waddr (CB'(cmd.element_index)),
		.wdata (NODE_BITS'(cmd.element_value)),
		.raddr (i_q[CB-1:0]),
		.rdata (cand_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			es_q <= ELITE_SIZE_RST;
			md_q <= MIN_DISTANCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ELITE_SIZE:   es_q <= cfg_data[4:0];
				REG_MIN_DISTANCE: md_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_s1 <= 1'b0;
		end else begin
			rdv_s1 <= (state_q == ST_HAM || state_q == ST_COPY)
				&& (i_q != IB'(NUM_CLUSTERS));
		end
	end

	always_ff @(posedge clk) begin
		wcl_s1 <= i_q[CB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (osend) begin
			ovalid_q <= 1'b1;
		end else if (rsp_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mode_q    <= M_CHK;
			cnt_q     <= '0;
			ptr_q     <= '0;
			p_q       <= '0;
			chosen_q  <= '0;
			i_q       <= '0;
			dist_q    <= '0;
			bestd_q   <= '0;
			found_q   <= 1'b0;
			acc_q     <= 1'b0;
			wasbest_q <= 1'b0;
			bgen_q    <= GEN_RST;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					i_q    <= '0;
					dist_q <= '0;
					if (cmd_xfer) begin
						unique case (cmd.opcode)
							OP_UPDATE: begin
								acc_q   <= 1'b0;
								ptr_q   <= '0;
								state_q <= ST_FIND;
							end
							OP_FARTHEST: begin
								ptr_q   <= '0;
								bestd_q <= '0;
								found_q <= 1'b0;
								mode_q  <= M_FAR;
								state_q <= (cnt_q == '0) ? ST_NOSOL : ST_HAM;
							end
							OP_BEST: begin
								chosen_q <= cnt_q - CNTB'(1);
								state_q  <= (cnt_q == '0) ? ST_NOSOL : ST_ESET;
							end
							OP_CLEAR: begin
								cnt_q   <= '0;
								bgen_q  <= GEN_RST;
								acc_q   <= 1'b0;
								state_q <= ST_STATUS;
							end
							default: ;
						endcase
					end
				end
				ST_FIND: begin
					if (ptr_q == cnt_q || cost_rd <= cost_q) begin
						p_q <= ptr_q;
						if (ptr_q != cnt_q && cost_rd == cost_q) begin
							state_q <= ST_STATUS;
						end else if (ptr_q == '0 && cnt_q >= lim) begin
							state_q <= ST_STATUS;
						end else if (ptr_q != cnt_q) begin
							mode_q  <= M_CHK;
							state_q <= ST_HAM;
						end else if (ptr_q == '0) begin
							state_q <= ST_COPY;
						end else begin
							ptr_q   <= ptr_q - CNTB'(1);
							mode_q  <= M_PRUNE;
							state_q <= ST_HAM;
						end
					end else begin
						ptr_q <= ptr_q + CNTB'(1);
					end
				end
				ST_HAM: begin
					if (!ham_end) begin
						i_q    <= i_q + IB'(1);
						dist_q <= dist_fin;
					end else begin
						i_q    <= '0;
						dist_q <= '0;
						unique case (mode_q)
							M_CHK: begin
								if (lt) begin
									state_q <= ST_STATUS;
								end else if (ptr_q + CNTB'(1) != cnt_q) begin
									ptr_q <= ptr_q + CNTB'(1);
								end else if (p_q == '0) begin
									state_q <= ST_COPY;
								end else begin
									ptr_q  <= p_q - CNTB'(1);
									mode_q <= M_PRUNE;
								end
							end
							M_PRUNE: begin
								if (lt) begin
									p_q   <= p_q - CNTB'(1);
									cnt_q <= cnt_q - CNTB'(1);
								end
								if (ptr_q == '0) begin
									state_q <= ST_COPY;
								end else begin
									ptr_q <= ptr_q - CNTB'(1);
								end
							end
							default: begin
								if (far_new) begin
									bestd_q  <= dist_fin;
									chosen_q <= ptr_q;
									found_q  <= 1'b1;
								end
								if (ptr_q + CNTB'(1) != cnt_q) begin
									ptr_q <= ptr_q + CNTB'(1);
								end else if (found_q || far_new) begin
									state_q <= ST_ESET;
								end else begin
									state_q <= ST_NOSOL;
								end
							end
						endcase
					end
				end
				ST_COPY: begin
					if (i_q != IB'(NUM_CLUSTERS)) begin
						i_q <= i_q + IB'(1);
					end else begin
						i_q       <= '0;
						wasbest_q <= (p_q == cnt_q);
						cnt_q     <= cnt_q + CNTB'(1);
						state_q   <= ST_EVICT;
					end
				end
				ST_EVICT: begin
					if (cnt_q > lim) begin
						cnt_q <= cnt_q - CNTB'(1);
					end else begin
						state_q <= ST_BEST;
					end
				end
				ST_BEST: begin
					if (wasbest_q) begin
						bgen_q <= gen_q;
					end
					acc_q   <= 1'b1;
					state_q <= ST_STATUS;
				end
				ST_STATUS, ST_NOSOL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ESET: begin
					i_q     <= '0;
					state_q <= ST_ERD;
				end
				ST_ERD: begin
					state_q <= ST_ELD;
				end
				ST_ELD: begin
					if (out_free) begin
						i_q     <= i_q + IB'(1);
						state_q <= (i_q == IB'(NUM_CLUSTERS - 1)) ? ST_IDLE : ST_ERD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			cost_q <= cmd.cost;
			gen_q  <= cmd.generation;
		end
		if (state_q == ST_BEST) begin
			best_q <= cost_rd;
		end
		if (state_q == ST_ESET) begin
			slot_q  <= ord_rd;
			ccost_q <= cost_rd;
		end
		if (out_free) begin
			out_q.accepted        <= 1'b0;
			out_q.best_cost       <= best_out;
			out_q.best_generation <= bgen_q;
			out_q.pool_count      <= 5'(cnt_q);
			out_q.out_index       <= '0;
			out_q.out_value       <= '0;
			out_q.last            <= 1'b1;
			if (state_q == ST_STATUS) begin
				out_q.result_kind <= KIND_STATUS;
				out_q.accepted    <= acc_q;
				out_q.chosen_cost <= '0;
			end else if (state_q == ST_NOSOL) begin
				out_q.result_kind <= KIND_NONE;
				out_q.chosen_cost <= NO_COST;
			end else begin
				out_q.result_kind <= KIND_ELEMENT;
				out_q.out_index   <= 5'(i_q);
				out_q.out_value   <= 8'(elem_rd);
				out_q.chosen_cost <= 32'(ccost_q);
				out_q.last        <= (i_q == IB'(NUM_CLUSTERS - 1));
			end
		end
	end
endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import epdu_pkg::*;

	localparam int NCL = NUM_CLUSTERS_DEF;
	localparam int PDEP = POOL_DEPTH_DEF;
	localparam int EXPQ = 4096;
	localparam int DN = 5 + NCL;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [5:0] cfg_data = '0;

	elite_pool_diversity_update u_dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	logic [7:0] mem_el [0:PDEP][0:NCL-1];
	logic [30:0] mem_cost [0:PDEP];
	int unsigned mem_cnt;
	logic [7:0] cand [0:NCL-1];
	logic [23:0] best_gen;
	logic [4:0] lim_reg;
	logic [5:0] dist_reg;

	rsp_t exp_q [EXPQ];
	int unsigned exp_wr = 0;
	int unsigned exp_rd = 0;
	int n_err = 0;
	int n_rsp = 0;
	int n_acc = 0;
	int n_query = 0;

	function automatic void exp_put(rsp_t r);
		exp_q[exp_wr % EXPQ] = r;
		exp_wr++;
	endfunction

	function automatic int unsigned pool_cap();
		if (lim_reg == 0) return 1;
		if (lim_reg > PDEP) return PDEP;
		return 32'(lim_reg);
	endfunction

	function automatic int unsigned dist_to(int unsigned s);
		int unsigned d;
		d = 0;
		for (int i = 0; i < NCL; i++)
			if (mem_el[s][i] != cand[i]) d++;
		return d;
	endfunction

	function automatic void drop_slot(int unsigned s);
		for (int unsigned k = s; k + 1 < mem_cnt; k++) begin
			mem_el[k] = mem_el[k+1];
			mem_cost[k] = mem_cost[k+1];
		end
		mem_cnt--;
	endfunction

	task automatic push_status(logic acc);
		rsp_t r;
		r = '0;
		r.result_kind = KIND_STATUS;
		r.accepted = acc;
		r.best_cost = mem_cnt ? $signed({1'b0, mem_cost[mem_cnt-1]}) : NO_COST;
		r.best_generation = best_gen;
		r.pool_count = mem_cnt[4:0];
		r.last = 1'b1;
		exp_put(r);
	endtask

	task automatic push_none();
		rsp_t r;
		r = '0;
		r.result_kind = KIND_NONE;
		r.best_cost = mem_cnt ? $signed({1'b0, mem_cost[mem_cnt-1]}) : NO_COST;
		r.best_generation = best_gen;
		r.pool_count = mem_cnt[4:0];
		r.chosen_cost = NO_COST;
		r.last = 1'b1;
		exp_put(r);
	endtask

	task automatic push_solution(int unsigned s);
		rsp_t r;
		for (int i = 0; i < NCL; i++) begin
			r = '0;
			r.result_kind = KIND_ELEMENT;
			r.best_cost = $signed({1'b0, mem_cost[mem_cnt-1]});
			r.best_generation = best_gen;
			r.pool_count = mem_cnt[4:0];
			r.out_index = i[4:0];
			r.out_value = mem_el[s][i];
			r.chosen_cost = $signed({1'b0, mem_cost[s]});
			r.last = (i == NCL - 1);
			exp_put(r);
		end
	endtask

	function automatic logic pool_update(logic [30:0] c, logic [23:0] g);
		int unsigned p, k;
		logic top;
		p = 0;
		while (p < mem_cnt && mem_cost[p] > c) p++;
		if (p < mem_cnt && mem_cost[p] == c) return 1'b0;
		if (p == 0 && mem_cnt >= pool_cap()) return 1'b0;
		for (k = p; k < mem_cnt; k++)
			if (dist_to(k) < dist_reg) return 1'b0;
		k = p;
		while (k > 0) begin
			k--;
			if (dist_to(k) < dist_reg) begin
				drop_slot(k);
				p--;
			end
		end
		top = (p == mem_cnt);
		for (k = mem_cnt; k > p; k--) begin
			mem_el[k] = mem_el[k-1];
			mem_cost[k] = mem_cost[k-1];
		end
		mem_el[p] = cand;
		mem_cost[p] = c;
		mem_cnt++;
		while (mem_cnt > pool_cap()) drop_slot(0);
		if (top) best_gen = g;
		return 1'b1;
	endfunction

	task automatic predict_cmd(cmd_t c);
		int unsigned bd, ch;
		logic a;
		case (c.opcode)
			OP_LOAD: cand[c.element_index] = c.element_value;
			OP_UPDATE: begin
				a = pool_update(c.cost, c.generation);
				if (a) n_acc++;
				push_status(a);
			end
			OP_FARTHEST: begin
				n_query++;
				bd = 0;
				ch = 0;
				for (int unsigned k = 0; k < mem_cnt; k++)
					if (dist_to(k) > bd) begin
						bd = dist_to(k);
						ch = k;
					end
				if (bd == 0) push_none();
				else push_solution(ch);
			end
			OP_BEST: begin
				n_query++;
				if (mem_cnt == 0) push_none();
				else push_solution(mem_cnt - 1);
			end
			OP_CLEAR: begin
				mem_cnt = 0;
				best_gen = GEN_RST;
				push_status(1'b0);
			end
			default: ;
		endcase
	endtask

	// response monitor
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			n_rsp++;
			if (exp_rd == exp_wr) begin
				n_err++;
				if (n_err <= 10) $display("unexpected response %p", rsp);
			end else begin
				rsp_t e;
				e = exp_q[exp_rd % EXPQ];
				exp_rd++;
				if (rsp !== e) begin
					n_err++;
					if (n_err <= 10) $display("mismatch: exp %p got %p", e, rsp);
				end
			end
		end
	end

	// receiver stall pattern
	int stall_mode = 0;
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: rsp_ready <= 1'b1;
			1: rsp_ready <= ($urandom_range(0, 3) != 0);
			2: rsp_ready <= 1'($urandom_range(0, 1));
			default: rsp_ready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	int burst_left = 0;

	task automatic send_cmd(cmd_t c);
		int gap;
		if (burst_left == 0) burst_left = $urandom_range(1, 8);
		burst_left--;
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		predict_cmd(c);
		if (burst_left == 0) begin
			cmd_valid <= 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic end_burst();
		if (burst_left != 0) begin
			burst_left = 0;
			cmd_valid <= 1'b0;
		end
	endtask

	task automatic write_reg(logic idx, logic [5:0] v);
		end_burst();
		while (exp_rd != exp_wr) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ELITE_SIZE) lim_reg = v[4:0];
		else dist_reg = v;
	endtask

	function automatic cmd_t mk(logic [2:0] op, logic [4:0] ix, logic [7:0] v,
			logic [30:0] c, logic [23:0] g);
		cmd_t r;
		r.opcode = op;
		r.element_index = ix;
		r.element_value = v;
		r.cost = c;
		r.generation = g;
		return r;
	endfunction

	task automatic load_all(logic [7:0] base, int spread);
		for (int i = 0; i < NCL; i++)
			send_cmd(mk(OP_LOAD, i[4:0], base + 8'($urandom_range(0, spread)),
				31'($urandom), 24'($urandom)));
	endtask

	cmd_t dir_tab [DN + 8];
	logic [7:0] mut_base;

	initial begin
		cmd_t c;
		lim_reg = ELITE_SIZE_RST;
		dist_reg = MIN_DISTANCE_RST;
		mem_cnt = 0;
		best_gen = GEN_RST;
		for (int i = 0; i < NCL; i++) cand[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pool, then extremes and special cases
		dir_tab[0] = mk(OP_BEST, '0, '0, '0, '0);
		dir_tab[1] = mk(OP_CLEAR, '0, '0, '0, '0);
		dir_tab[2] = mk(3'd5, 5'd31, 8'hff, '1, '1);
		dir_tab[3] = mk(3'd7, '0, '0, '0, '0);
		dir_tab[4] = mk(3'd6, '0, '0, '0, '0);
		for (int i = 0; i < NCL; i++)
			dir_tab[5 + i] = mk(OP_LOAD, i[4:0], i[0] ? 8'hff : 8'h00, '0, '0);
		dir_tab[DN + 0] = mk(OP_FARTHEST, '0, '0, '0, '0);
		dir_tab[DN + 1] = mk(OP_UPDATE, '0, '0, 31'h7fffffff, 24'hffffff);
		dir_tab[DN + 2] = mk(OP_UPDATE, '0, '0, 31'h7fffffff, 24'h0);
		dir_tab[DN + 3] = mk(OP_UPDATE, '0, '0, 31'd0, 24'd5);
		dir_tab[DN + 4] = mk(OP_LOAD, 5'd3, 8'h55, '0, '0);
		dir_tab[DN + 5] = mk(OP_UPDATE, '0, '0, 31'd0, 24'd6);
		dir_tab[DN + 6] = mk(OP_FARTHEST, '0, '0, '0, '0);
		dir_tab[DN + 7] = mk(OP_BEST, '0, '0, '0, '0);
		foreach (dir_tab[i]) send_cmd(dir_tab[i]);

		// random phases over several register settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(REG_ELITE_SIZE, 6'd0); write_reg(REG_MIN_DISTANCE, 6'd0); end
				1: begin write_reg(REG_ELITE_SIZE, 6'd16); write_reg(REG_MIN_DISTANCE, 6'd32); end
				2: begin write_reg(REG_ELITE_SIZE, 6'd31); write_reg(REG_MIN_DISTANCE, 6'd2); end
				3: begin write_reg(REG_ELITE_SIZE, 6'd4); write_reg(REG_MIN_DISTANCE, 6'd63); end
				4: begin write_reg(REG_ELITE_SIZE, 6'd2); write_reg(REG_MIN_DISTANCE, 6'd5); end
				default: begin write_reg(REG_ELITE_SIZE, 6'd10); write_reg(REG_MIN_DISTANCE, 6'd1); end
			endcase
			mut_base = 8'($urandom);
			for (int n = 0; n < 2; n++) begin
				case ($urandom_range(0, 9))
					0: load_all(8'($urandom), 255);
					1, 2, 3, 4: begin
						for (int m = $urandom_range(0, 4); m > 0; m--)
							send_cmd(mk(OP_LOAD, 5'($urandom), mut_base + 8'($urandom_range(0, 3)),
								31'($urandom), 24'($urandom)));
						c = mk(OP_UPDATE, 5'($urandom), 8'($urandom),
							($urandom_range(0, 3) == 0) ? 31'($urandom_range(0, 20)) : 31'($urandom),
							24'($urandom));
						send_cmd(c);
					end
					5, 6: send_cmd(mk(OP_FARTHEST, 5'($urandom), 8'($urandom), 31'($urandom), 24'($urandom)));
					7: send_cmd(mk(OP_BEST, 5'($urandom), 8'($urandom), 31'($urandom), 24'($urandom)));
					8: send_cmd(mk(3'($urandom_range(5, 7)), 5'($urandom), 8'($urandom), 31'($urandom), 24'($urandom)));
					default: if ($urandom_range(0, 3) == 0) send_cmd(mk(OP_CLEAR, '0, '0, '0, '0));
						else send_cmd(mk(OP_UPDATE, '0, '0, 31'($urandom), 24'($urandom)));
				endcase
			end
			send_cmd(mk(OP_BEST, '0, '0, '0, '0));
			send_cmd(mk(OP_FARTHEST, '0, '0, '0, '0));
		end

		end_burst();
		while (exp_rd != exp_wr) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("%0d responses checked, %0d accepted updates, %0d queries", n_rsp, n_acc, n_query);
		$display("register settings covered limit 0..31 and distance 0..63");
		if (n_err == 0 && exp_rd == exp_wr)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

endmodule
